@@ hw/rtl/hed_pkg.sv @@
// hed_pkg: shared constants, types and the entity name ROM for the HTML
// entity decoder. No dependencies.
`default_nettype none
package hed_pkg;
    localparam int MAX_SPAN_DEF = 12;
    localparam int ROM_SIZE     = 74;
    localparam int NAME_LEN     = 6;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;

    typedef struct packed {
        logic [47:0] nm;
        logic [2:0]  len;
        logic [7:0]  cp;
    } rom_entry_t;

    typedef struct packed {
        logic       load;
        logic       clr;
        logic       shift;
        logic [4:0] shift_amt;
    } dp_cmd_t;

    function automatic rom_entry_t mk(input string s, input logic [7:0] cp);
        rom_entry_t r;
        r.nm  = '0;
        r.len = 3'(s.len());
        r.cp  = cp;
        for (int i = 0; i < NAME_LEN; i++)
            if (i < s.len()) r.nm[i*8 +: 8] = s[i];
        return r;
    endfunction

    function automatic rom_entry_t name_rom(input logic [6:0] idx);
        rom_entry_t r;
        r = '0;
        case (idx)
            7'd0: r = mk("amp", 8'h26);     7'd1: r = mk("lt", 8'h3C);
            7'd2: r = mk("gt", 8'h3E);      7'd3: r = mk("quot", 8'h22);
            7'd4: r = mk("apos", 8'h27);    7'd5: r = mk("nbsp", 8'hA0);
            7'd6: r = mk("iexcl", 8'hA1);   7'd7: r = mk("cent", 8'hA2);
            7'd8: r = mk("pound", 8'hA3);   7'd9: r = mk("copy", 8'hA9);
            7'd10: r = mk("ordf", 8'hAA);   7'd11: r = mk("laquo", 8'hAB);
            7'd12: r = mk("reg", 8'hAE);    7'd13: r = mk("deg", 8'hB0);
            7'd14: r = mk("plusmn", 8'hB1); 7'd15: r = mk("sup2", 8'hB2);
            7'd16: r = mk("sup3", 8'hB3);   7'd17: r = mk("micro", 8'hB5);
            7'd18: r = mk("para", 8'hB6);   7'd19: r = mk("middot", 8'hB7);
            7'd20: r = mk("ordm", 8'hBA);   7'd21: r = mk("raquo", 8'hBB);
            7'd22: r = mk("frac14", 8'hBC); 7'd23: r = mk("frac12", 8'hBD);
            7'd24: r = mk("frac34", 8'hBE); 7'd25: r = mk("Agrave", 8'hC0);
            7'd26: r = mk("Aacute", 8'hC1); 7'd27: r = mk("Acirc", 8'hC2);
            7'd28: r = mk("Atilde", 8'hC3); 7'd29: r = mk("Auml", 8'hC4);
            7'd30: r = mk("Ccedil", 8'hC7); 7'd31: r = mk("Egrave", 8'hC8);
            7'd32: r = mk("Eacute", 8'hC9); 7'd33: r = mk("Ecirc", 8'hCA);
            7'd34: r = mk("Euml", 8'hCB);   7'd35: r = mk("Igrave", 8'hCC);
            7'd36: r = mk("Iacute", 8'hCD); 7'd37: r = mk("Icirc", 8'hCE);
            7'd38: r = mk("Iuml", 8'hCF);   7'd39: r = mk("Ograve", 8'hD2);
            7'd40: r = mk("Oacute", 8'hD3); 7'd41: r = mk("Ocirc", 8'hD4);
            7'd42: r = mk("Otilde", 8'hD5); 7'd43: r = mk("Ouml", 8'hD6);
            7'd44: r = mk("Ugrave", 8'hD9); 7'd45: r = mk("Uacute", 8'hDA);
            7'd46: r = mk("Ucirc", 8'hDB);  7'd47: r = mk("Uuml", 8'hDC);
            7'd48: r = mk("Yacute", 8'hDD); 7'd49: r = mk("agrave", 8'hE0);
            7'd50: r = mk("aacute", 8'hE1); 7'd51: r = mk("acirc", 8'hE2);
            7'd52: r = mk("atilde", 8'hE3); 7'd53: r = mk("auml", 8'hE4);
            7'd54: r = mk("ccedil", 8'hE7); 7'd55: r = mk("egrave", 8'hE8);
            7'd56: r = mk("eacute", 8'hE9); 7'd57: r = mk("ecirc", 8'hEA);
            7'd58: r = mk("euml", 8'hEB);   7'd59: r = mk("igrave", 8'hEC);
            7'd60: r = mk("iacute", 8'hED); 7'd61: r = mk("icirc", 8'hEE);
            7'd62: r = mk("iuml", 8'hEF);   7'd63: r = mk("ograve", 8'hF2);
            7'd64: r = mk("oacute", 8'hF3); 7'd65: r = mk("ocirc", 8'hF4);
            7'd66: r = mk("otilde", 8'hF5); 7'd67: r = mk("ouml", 8'hF6);
            7'd68: r = mk("ugrave", 8'hF9); 7'd69: r = mk("uacute", 8'hFA);
            7'd70: r = mk("ucirc", 8'hFB);  7'd71: r = mk("uuml", 8'hFC);
            7'd72: r = mk("yacute", 8'hFD); 7'd73: r = mk("yuml", 8'hFF);
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/hed_datapath.sv @@
// hed_datapath: reference byte buffer (shift register) with append and
// left shift. Depends on hed_pkg.
`default_nettype none
module hed_datapath #(
    parameter int MAX_SPAN = hed_pkg::MAX_SPAN_DEF
) (
    input  wire logic                   aclk,
    input  wire hed_pkg::dp_cmd_t       cmd,
    input  wire logic [7:0]             wr_byte,
    input  wire logic [$clog2(MAX_SPAN+1)-1:0] fill,
    input  wire logic [$clog2(MAX_SPAN)-1:0]   rd_idx,
    output logic [7:0]                  rd_byte
);
    import hed_pkg::*;
    localparam int IW = $clog2(MAX_SPAN);
    logic [7:0] buf_reg [MAX_SPAN];
    logic [5:0] amt;

    assign amt     = {1'b0, cmd.shift_amt};
    assign rd_byte = buf_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            buf_reg[fill[IW-1:0]] <= wr_byte;
        end else if (cmd.shift) begin
            for (int i = 0; i < MAX_SPAN; i++)
                if (i + int'(amt) < MAX_SPAN) buf_reg[i] <= buf_reg[i + int'(amt)];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/hed_ctrl.sv @@
// hed_ctrl: controller state machine; sequences literal emits, name ROM
// scan, numeric parse and UTF-8 output. Depends on hed_pkg, drives hed_datapath.
`default_nettype none
module hed_ctrl #(
    parameter int MAX_SPAN = hed_pkg::MAX_SPAN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_stream_end,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_run_last,
    output logic             m_final_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output hed_pkg::dp_cmd_t cmd,
    output logic [7:0]       wr_byte,
    output logic [$clog2(MAX_SPAN+1)-1:0] fill,
    output logic [$clog2(MAX_SPAN)-1:0]   rd_idx,
    input  wire logic [7:0]  rd_byte
);
    import hed_pkg::*;
    localparam int FW = $clog2(MAX_SPAN+1);
    localparam int IW = $clog2(MAX_SPAN);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_END  = 4'd1;
    localparam logic [3:0] ST_NAME = 4'd2;
    localparam logic [3:0] ST_NUM  = 4'd3;
    localparam logic [3:0] ST_UTF  = 4'd4;
    localparam logic [3:0] ST_LIT  = 4'd5;
    localparam logic [3:0] ST_EXP  = 4'd6;
    localparam logic [3:0] ST_TAIL = 4'd7;

    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    logic [3:0]    state_reg, state_next;
    logic          inref_reg, inref_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] pos_reg, pos_next;
    logic [6:0]    rom_reg, rom_next;
    logic [16:0]   acc_reg, acc_next;
    logic          hex_reg, hex_next;
    logic [1:0]    ucnt_reg, ucnt_next;
    logic [7:0]    ob_reg, ob_next;
    logic          ov_reg, ov_next;
    logic          orl_reg, orl_next;
    logic          ofb_reg, ofb_next;
    logic          end_reg, end_next;
    logic [7:0]    stg_reg, stg_next;
    logic          stg_v_reg, stg_v_next;

    rom_entry_t re;
    logic [7:0] nch;
    logic [3:0] dig;
    logic       dig_ok;
    logic [20:0] prod;
    logic [15:0] cp16;
    logic        busy_emit;
    logic        put_ok;
    logic        put_req;
    logic [7:0]  put_byte;
    logic        fin_req;
    logic        num_fail;
    logic        utf_last;

    assign re    = name_rom(rom_reg);
    assign nch   = re.nm[pos_reg[2:0]*8 +: 8];
    assign fill  = fill_reg;
    assign rd_idx = pos_reg[IW-1:0];
    assign wr_byte = s_in_byte;
    assign cp16  = acc_reg[15:0];

    assign m_out_byte   = ob_reg;
    assign m_valid      = ov_reg;
    assign m_run_last   = orl_reg;
    assign m_final_byte = ofb_reg;
    assign busy_emit    = ov_reg && !m_ready;
    // one staged word ahead of the output register, so run_last is known at emit
    assign put_ok       = !stg_v_reg || !busy_emit;
    assign s_ready      = (state_reg == ST_IDLE);

    always_comb begin
        dig = 4'd0;
        dig_ok = 1'b0;
        if (rd_byte >= 8'h30 && rd_byte <= 8'h39) begin
            dig = 4'(rd_byte - 8'h30); dig_ok = 1'b1;
        end else if (hex_reg && rd_byte >= 8'h61 && rd_byte <= 8'h66) begin
            dig = 4'(rd_byte - 8'h57); dig_ok = 1'b1;
        end else if (hex_reg && rd_byte >= 8'h41 && rd_byte <= 8'h46) begin
            dig = 4'(rd_byte - 8'h37); dig_ok = 1'b1;
        end
        prod = hex_reg ? {acc_reg, 4'd0} : (21'(acc_reg) * 21'd10);
        prod = prod + 21'(dig);
    end

    always_comb begin
        state_next = state_reg;  inref_next = inref_reg;  fill_next = fill_reg;
        pos_next = pos_reg;      rom_next = rom_reg;      acc_next = acc_reg;
        hex_next = hex_reg;      ucnt_next = ucnt_reg;    ob_next = ob_reg;
        orl_next = orl_reg;      ofb_next = ofb_reg;      end_next = end_reg;
        stg_next = stg_reg;      stg_v_next = stg_v_reg;
        ov_next = ov_reg && !m_ready;
        cmd = '0;
        put_req = 1'b0;
        put_byte = '0;
        fin_req = 1'b0;
        num_fail = 1'b0;
        utf_last = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    end_next = s_stream_end;
                    state_next = ST_END;
                    if (!inref_reg) begin
                        if (s_in_byte == CH_AMP) begin
                            inref_next = 1'b1;
                            fill_next = '0;
                        end else begin
                            put_req = 1'b1; put_byte = s_in_byte;
                        end
                    end else if (s_in_byte == CH_SEMI) begin
                        rom_next = '0; pos_next = '0;
                        state_next = ST_NAME;
                    end else begin
                        cmd.load = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        if (fill_reg == FW'(MAX_SPAN - 1)) begin
                            put_req = 1'b1; put_byte = CH_AMP;
                            pos_next = '0; state_next = ST_EXP;
                        end
                    end
                end
            end
            ST_END: begin
                // stream end flushes an open reference literally
                if (end_reg && inref_reg) begin
                    put_req = 1'b1; put_byte = CH_AMP;
                    if (put_ok) begin
                        pos_next = '0; state_next = ST_TAIL;
                    end
                end else begin
                    fin_req = 1'b1;
                end
            end
            ST_TAIL: begin
                if (pos_reg < fill_reg) begin
                    put_req = 1'b1; put_byte = rd_byte;
                    if (put_ok) pos_next = pos_reg + 1'b1;
                end else begin
                    inref_next = 1'b0; fill_next = '0;
                    fin_req = 1'b1;
                end
            end
            ST_LIT: begin
                // '&' already staged; held bytes then ';'
                put_req = 1'b1;
                if (pos_reg < fill_reg) begin
                    put_byte = rd_byte;
                    if (put_ok) pos_next = pos_reg + 1'b1;
                end else begin
                    put_byte = CH_SEMI;
                    if (put_ok) begin
                        inref_next = 1'b0; fill_next = '0;
                        state_next = ST_END;
                    end
                end
            end
            ST_EXP: begin
                if (pos_reg < fill_reg && rd_byte != CH_AMP) begin
                    put_req = 1'b1; put_byte = rd_byte;
                    if (put_ok) pos_next = pos_reg + 1'b1;
                end else if (pos_reg < fill_reg) begin
                    cmd.shift = 1'b1;
                    cmd.shift_amt = 5'(pos_reg + 1'b1);
                    fill_next = fill_reg - pos_reg - 1'b1;
                    state_next = ST_END;
                end else begin
                    inref_next = 1'b0; fill_next = '0;
                    state_next = ST_END;
                end
            end
            ST_NAME: begin
                if (rom_reg == 7'(ROM_SIZE)) begin
                    pos_next = '0; acc_next = '0; hex_next = 1'b0;
                    state_next = ST_NUM;
                end else if (fill_reg != FW'(re.len)) begin
                    rom_next = rom_reg + 1'b1; pos_next = '0;
                end else if (pos_reg == fill_reg) begin
                    acc_next = 17'(re.cp); state_next = ST_UTF; ucnt_next = '0;
                end else if (rd_byte == nch) begin
                    pos_next = pos_reg + 1'b1;
                end else begin
                    rom_next = rom_reg + 1'b1; pos_next = '0;
                end
            end
            ST_NUM: begin
                if (pos_reg == '0) begin
                    if (fill_reg < FW'(2) || rd_byte != CH_HASH) num_fail = 1'b1;
                    else pos_next = FW'(1);
                end else if (pos_reg == FW'(1) && !hex_reg
                             && (rd_byte == CH_X_LO || rd_byte == CH_X_UP)) begin
                    hex_next = 1'b1; pos_next = FW'(2);
                    if (fill_reg == FW'(2)) num_fail = 1'b1;
                end else if (pos_reg == fill_reg) begin
                    if (cp16 >= 16'hD800 && cp16 <= 16'hDFFF) begin
                        num_fail = 1'b1;
                    end else begin
                        state_next = ST_UTF; ucnt_next = '0;
                    end
                end else if (!dig_ok || prod > 21'h0FFFF) begin
                    num_fail = 1'b1;
                end else begin
                    acc_next = 17'(prod); pos_next = pos_reg + 1'b1;
                end
                if (num_fail) begin
                    put_req = 1'b1; put_byte = CH_AMP;
                    pos_next = '0; state_next = ST_LIT;
                end
            end
            ST_UTF: begin
                put_req = 1'b1;
                if (cp16 <= 16'h7F) begin
                    put_byte = cp16[7:0]; utf_last = 1'b1;
                end else if (cp16 <= 16'h7FF) begin
                    if (ucnt_reg == 2'd0) put_byte = 8'hC0 | 8'(cp16[10:6]);
                    else begin
                        put_byte = 8'h80 | {2'b0, cp16[5:0]}; utf_last = 1'b1;
                    end
                end else begin
                    if (ucnt_reg == 2'd0) put_byte = 8'hE0 | {4'b0, cp16[15:12]};
                    else if (ucnt_reg == 2'd1) put_byte = 8'h80 | {2'b0, cp16[11:6]};
                    else begin
                        put_byte = 8'h80 | {2'b0, cp16[5:0]}; utf_last = 1'b1;
                    end
                end
                if (put_ok) begin
                    ucnt_next = ucnt_reg + 1'b1;
                    if (utf_last) begin
                        inref_next = 1'b0; fill_next = '0;
                        state_next = ST_END;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (put_req && put_ok) begin
            if (stg_v_reg) begin
                ob_next = stg_reg; ov_next = 1'b1;
                orl_next = 1'b0; ofb_next = 1'b0;
            end
            stg_next = put_byte; stg_v_next = 1'b1;
        end
        if (fin_req) begin
            if (!stg_v_reg) begin
                state_next = ST_IDLE;
            end else if (!busy_emit) begin
                ob_next = stg_reg; ov_next = 1'b1;
                orl_next = 1'b1; ofb_next = end_reg;
                stg_v_next = 1'b0;
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; inref_reg <= 1'b0; fill_reg <= '0;
            ov_reg <= 1'b0; stg_v_reg <= 1'b0; end_reg <= 1'b0;
        end else begin
            state_reg <= state_next; inref_reg <= inref_next; fill_reg <= fill_next;
            ov_reg <= ov_next; stg_v_reg <= stg_v_next; end_reg <= end_next;
        end
        pos_reg <= pos_next; rom_reg <= rom_next; stg_reg <= stg_next;
        acc_reg <= acc_next; hex_reg <= hex_next; ucnt_reg <= ucnt_next;
        ob_reg <= ob_next; orl_reg <= orl_next; ofb_reg <= ofb_next;
    end
endmodule
`default_nettype wire

@@ hw/rtl/html_entity_decoder.sv @@
// html_entity_decoder: top level, joins hed_ctrl and hed_datapath.
// Depends on hed_pkg.
//
//  channel | ports                               | direction
//  s_      | s_in_byte s_stream_end s_valid/ready | in, one text byte a word
//  m_      | m_out_byte m_run_last m_final_byte  | out, one byte a word
//
// Plain bytes pass through IDLE and END. A ';' item scans the name ROM
// serially, entry by entry, comparing characters only where the length fits,
// then walks the held bytes and emits the output bytes. Reset is
// synchronous, active low, and clears control only. One word is staged ahead
// of the output register; a stalled m_ side holds the controller there.
`default_nettype none
module html_entity_decoder #(
    parameter int MAX_SPAN = hed_pkg::MAX_SPAN_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_stream_end,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_run_last,
    output logic            m_final_byte,
    output logic            m_valid,
    input  wire logic       m_ready
);
    import hed_pkg::*;
    dp_cmd_t cmd;
    logic [7:0] wr_byte, rd_byte;
    logic [$clog2(MAX_SPAN+1)-1:0] fill;
    logic [$clog2(MAX_SPAN)-1:0]   rd_idx;

    hed_ctrl #(.MAX_SPAN(MAX_SPAN)) u_ctrl (
        .aclk, .aresetn, .s_in_byte, .s_stream_end, .s_valid, .s_ready,
        .m_out_byte, .m_run_last, .m_final_byte, .m_valid, .m_ready,
        .cmd, .wr_byte, .fill, .rd_idx, .rd_byte
    );

    hed_datapath #(.MAX_SPAN(MAX_SPAN)) u_dp (
        .aclk, .cmd, .wr_byte, .fill, .rd_idx, .rd_byte
    );
endmodule
`default_nettype wire
